FILE: hdl/svec_pkg.sv
// ----------------------------------------------------------------------------
// svec_pkg
// Shared widths and payload types of the 3d steering vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package svec_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int MAG_W   = 32;
   localparam int SQ_W    = 64;
   localparam int SPD_W   = 31;
   localparam int SPD2_W  = 62;
   localparam int SUM_W   = 66;
   localparam int NUM_W   = 126;
   localparam int QUO_W   = 62;
   localparam int ROOT_W  = 31;
   localparam int REM_W   = 34;
   localparam int HALF_W  = 32;

   typedef struct packed {
      logic signed [COORD_W-1:0] here_x;
      logic signed [COORD_W-1:0] here_y;
      logic signed [COORD_W-1:0] here_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
      logic        [SPD_W-1:0]   speed;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] vel_z;
      logic                      zero_length;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/svec_div.sv
// ----------------------------------------------------------------------------
// svec_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module svec_div (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [svec_pkg::NUM_W-1:0]    num_in,
   input  wire logic [svec_pkg::SUM_W-1:0]    den_in,
   output      logic [svec_pkg::QUO_W-1:0]    quo_out
);

   localparam int QW = svec_pkg::QUO_W;
   localparam int SW = svec_pkg::SUM_W;

   logic [SW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [SW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [SW-1:0] rem_cur;
      logic [QW-1:0] low_cur;
      logic [SW-1:0] den_cur;
      logic [QW-1:0] quo_cur;
      logic [SW:0]   trial;
      logic [SW:0]   diff;
      logic          ge;
      logic [SW-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_cur = {{(SW-(svec_pkg::NUM_W-QW)){1'b0}}, num_in[svec_pkg::NUM_W-1:QW]};
         assign low_cur = num_in[QW-1:0];
         assign den_cur = den_in;
         assign quo_cur = '0;
      end else begin : g_rest
         assign rem_cur = rem_ff[k-1];
         assign low_cur = low_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      assign trial  = {rem_cur, low_cur[QW-1]};
      assign ge     = trial >= {1'b0, den_cur};
      assign diff   = trial - {1'b0, den_cur};
      assign rem_in = ge ? diff[SW-1:0] : trial[SW-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= {low_cur[QW-2:0], 1'b0};
            den_ff[k] <= den_cur;
            quo_ff[k] <= {quo_cur[QW-2:0], ge};
         end
      end
   end

   assign quo_out = quo_ff[QW-1];

endmodule

`default_nettype wire

FILE: hdl/svec_sqrt.sv
// ----------------------------------------------------------------------------
// svec_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module svec_sqrt (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [svec_pkg::QUO_W-1:0]    x_in,
   output      logic [svec_pkg::ROOT_W-1:0]   root_out
);

   localparam int RW = svec_pkg::ROOT_W;
   localparam int XW = svec_pkg::QUO_W;
   localparam int MW = svec_pkg::REM_W;

   logic [MW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [XW-1:0] x_ff    [RW];

   for (genvar j = 0; j < RW; j++) begin : g_step
      logic [MW-1:0] rem_cur;
      logic [RW-1:0] root_cur;
      logic [XW-1:0] x_cur;
      logic [MW-1:0] part;
      logic [MW-1:0] trial;
      logic          ge;

      if (j == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign x_cur    = x_in;
      end else begin : g_rest
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
         assign x_cur    = x_ff[j-1];
      end

      assign part  = {rem_cur[MW-3:0], x_cur[XW-1:XW-2]};
      assign trial = {1'b0, root_cur, 2'b01};
      assign ge    = part >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? (part - trial) : part;
            root_ff[j] <= {root_cur[RW-2:0], ge};
            x_ff[j]    <= {x_cur[XW-3:0], 2'b00};
         end
      end
   end

   assign root_out = root_ff[RW-1];

endmodule

`default_nettype wire

FILE: hdl/steering_vector_3d_top.sv
// ----------------------------------------------------------------------------
// steering_vector_3d_top
// Velocity of a given speed pointing from a position toward a target.
// one request per cycle sustained, as long as the pipeline is not held;
// the pipeline holds as a whole only while a result waits and rsp_ready is low
// depth set by the 62-step divider and the 31-step square root pipelines
// reset clears the valid bits of every stage; data registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module steering_vector_3d_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire svec_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      svec_pkg::rsp_type rsp_data
);

   localparam int FRONT = 4;
   localparam int SIDE  = svec_pkg::QUO_W + svec_pkg::ROOT_W;
   localparam int LAT   = FRONT + SIDE + 1;
   localparam int MW    = svec_pkg::MAG_W;
   localparam int HW    = svec_pkg::HALF_W;

   logic en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: differences
   logic signed [svec_pkg::DIFF_W-1:0] d [3];
   logic [MW-1:0]            mag1_ff [3];
   logic [2:0]               sgn1_ff;
   logic [svec_pkg::SPD_W-1:0] spd1_ff;

   assign d[0] = svec_pkg::DIFF_W'(req_data.target_x) - svec_pkg::DIFF_W'(req_data.here_x);
   assign d[1] = svec_pkg::DIFF_W'(req_data.target_y) - svec_pkg::DIFF_W'(req_data.here_y);
   assign d[2] = svec_pkg::DIFF_W'(req_data.target_z) - svec_pkg::DIFF_W'(req_data.here_z);

   // stage 2: squares
   logic [svec_pkg::SQ_W-1:0]   sq2_ff [3];
   logic [svec_pkg::SPD2_W-1:0] spd2_ff;
   logic [2:0]                  sgn2_ff;

   // stage 3: sum and partial products
   logic [svec_pkg::SUM_W-1:0] sum3_ff;
   logic [2*HW-1:0]            pp00_ff [3];
   logic [2*HW-1:0]            pp01_ff [3];
   logic [2*HW-1:0]            pp10_ff [3];
   logic [2*HW-1:0]            pp11_ff [3];
   logic [2:0]                 sgn3_ff;

   // stage 4: numerators
   logic [svec_pkg::NUM_W-1:0] num4_ff [3];
   logic [svec_pkg::SUM_W-1:0] sum4_ff;
   logic [3:0]                 side4_ff;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [svec_pkg::DIFF_W-1:0] neg;
      assign neg = -d[i];

      always_ff @(posedge clock) begin
         if (en) begin
            mag1_ff[i] <= d[i][svec_pkg::DIFF_W-1] ? neg[MW-1:0] : d[i][MW-1:0];
            sq2_ff[i]  <= svec_pkg::SQ_W'(mag1_ff[i]) * svec_pkg::SQ_W'(mag1_ff[i]);
            pp00_ff[i] <= (2*HW)'(sq2_ff[i][HW-1:0]) * (2*HW)'(spd2_ff[HW-1:0]);
            pp01_ff[i] <= (2*HW)'(sq2_ff[i][HW-1:0])
                          * (2*HW)'(spd2_ff[svec_pkg::SPD2_W-1:HW]);
            pp10_ff[i] <= (2*HW)'(sq2_ff[i][2*HW-1:HW]) * (2*HW)'(spd2_ff[HW-1:0]);
            pp11_ff[i] <= (2*HW)'(sq2_ff[i][2*HW-1:HW])
                          * (2*HW)'(spd2_ff[svec_pkg::SPD2_W-1:HW]);
            num4_ff[i] <= svec_pkg::NUM_W'(pp00_ff[i])
                          + (svec_pkg::NUM_W'(pp01_ff[i]) << HW)
                          + (svec_pkg::NUM_W'(pp10_ff[i]) << HW)
                          + (svec_pkg::NUM_W'(pp11_ff[i]) << (2*HW));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgn1_ff  <= {d[2][svec_pkg::DIFF_W-1], d[1][svec_pkg::DIFF_W-1],
                      d[0][svec_pkg::DIFF_W-1]};
         spd1_ff  <= req_data.speed;
         spd2_ff  <= svec_pkg::SPD2_W'(spd1_ff) * svec_pkg::SPD2_W'(spd1_ff);
         sgn2_ff  <= sgn1_ff;
         sum3_ff  <= svec_pkg::SUM_W'(sq2_ff[0]) + svec_pkg::SUM_W'(sq2_ff[1])
                     + svec_pkg::SUM_W'(sq2_ff[2]);
         sgn3_ff  <= sgn2_ff;
         sum4_ff  <= sum3_ff;
         side4_ff <= {sum3_ff == '0, sgn3_ff};
      end
   end

   // divide and root per lane
   logic [svec_pkg::QUO_W-1:0]  quo  [3];
   logic [svec_pkg::ROOT_W-1:0] root [3];

   for (genvar i = 0; i < 3; i++) begin : g_unit
      svec_div u_div (
         .clock   (clock),
         .en      (en),
         .num_in  (num4_ff[i]),
         .den_in  (sum4_ff),
         .quo_out (quo[i])
      );

      svec_sqrt u_sqrt (
         .clock    (clock),
         .en       (en),
         .x_in     (quo[i]),
         .root_out (root[i])
      );
   end

   // sign and zero flag alongside the long units
   logic [3:0] side_ff [SIDE];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side4_ff;
         for (int k = 1; k < SIDE; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // output register
   logic [svec_pkg::COORD_W-1:0] vel [3];
   svec_pkg::rsp_type rsp_ff;

   for (genvar i = 0; i < 3; i++) begin : g_out
      logic [svec_pkg::COORD_W-1:0] mag;
      assign mag    = svec_pkg::COORD_W'(root[i]);
      assign vel[i] = side_ff[SIDE-1][3] ? '0 : (side_ff[SIDE-1][i] ? -mag : mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.vel_x       <= vel[0];
         rsp_ff.vel_y       <= vel[1];
         rsp_ff.vel_z       <= vel[2];
         rsp_ff.zero_length <= side_ff[SIDE-1][3];
      end
   end

   assign rsp_data = rsp_ff;

   a_zero_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.vel_x == '0 && rsp_data.vel_y == '0 && rsp_data.vel_z == '0)
      else $error("zero length result with nonzero velocity");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_accept_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while output is empty");

endmodule

`default_nettype wire

FILE: bench/steering_vector_3d_checker.sv
// ----------------------------------------------------------------------------
// steering_vector_3d_checker
// Watches both channels of the steering vector block, computes the expected
// velocity of every accepted request and compares it with each result.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_vector_3d_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire svec_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire svec_pkg::rsp_type rsp_data,
   output      int                fail_count,
   output      int                pending_count
);

   svec_pkg::rsp_type velocity_queue[$];

   function automatic logic [63:0] root_floor(logic [127:0] x);
      logic [127:0] res;
      logic [127:0] bit_w;
      res = '0;
      bit_w = 128'd1 << 126;
      while (bit_w > x) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (x >= res + bit_w) begin
            x = x - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res[63:0];
   endfunction

   function automatic svec_pkg::rsp_type steer(svec_pkg::req_type r);
      svec_pkg::rsp_type o;
      logic signed [svec_pkg::DIFF_W-1:0] d[3];
      logic [svec_pkg::DIFF_W-1:0] m[3];
      logic [127:0] sum;
      logic [127:0] spd2;
      logic [127:0] q;
      logic [63:0] root;
      logic [31:0] comp[3];
      d[0] = $signed({r.target_x[31], r.target_x}) - $signed({r.here_x[31], r.here_x});
      d[1] = $signed({r.target_y[31], r.target_y}) - $signed({r.here_y[31], r.here_y});
      d[2] = $signed({r.target_z[31], r.target_z}) - $signed({r.here_z[31], r.here_z});
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = d[i][svec_pkg::DIFF_W-1] ? -d[i] : d[i];
         sum = sum + 128'(m[i]) * 128'(m[i]);
      end
      spd2 = 128'(r.speed) * 128'(r.speed);
      o = '0;
      if (sum == 0) begin
         o.zero_length = 1'b1;
         return o;
      end
      for (int i = 0; i < 3; i++) begin
         q = (128'(m[i]) * 128'(m[i]) * spd2) / sum;
         root = root_floor(q);
         comp[i] = d[i][svec_pkg::DIFF_W-1] ? -root[31:0] : root[31:0];
      end
      o.vel_x = comp[0];
      o.vel_y = comp[1];
      o.vel_z = comp[2];
      return o;
   endfunction

   always @(posedge clock) begin
      svec_pkg::rsp_type want;
      int delta;
      delta = 0;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
         velocity_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            velocity_queue.push_back(steer(req_data));
            delta = delta + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (velocity_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %h", rsp_data);
            end else begin
               want = velocity_queue.pop_front();
               delta = delta - 1;
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch exp x=%h y=%h z=%h zl=%b got x=%h y=%h z=%h zl=%b",
                        want.vel_x, want.vel_y, want.vel_z, want.zero_length,
                        rsp_data.vel_x, rsp_data.vel_y, rsp_data.vel_z,
                        rsp_data.zero_length);
               end
            end
         end
         pending_count <= pending_count + delta;
      end
   end

endmodule

`default_nettype wire

FILE: bench/tb_steering_vector_3d_top.sv
// ----------------------------------------------------------------------------
// tb_steering_vector_3d_top
// Drives directed and random requests with random gaps and result stalls,
// including a long stall that backs up the pipeline, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_steering_vector_3d_top;

   localparam int RANDOM_COUNT = 800;
   localparam int WATCHDOG_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   svec_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   svec_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending_count;
   int                idle_cycles = 0;
   bit                sending_done = 1'b0;
   bit                hold_off = 1'b0;
   bit                hold_now = 1'b0;

   always #10 clock = ~clock;

   steering_vector_3d_top dut (.*);

   steering_vector_3d_checker checker_i (.*);

   function automatic int gap_length();
      if ($urandom_range(9) == 0) return $urandom_range(40, 5);
      if ($urandom_range(2) == 0) return 0;
      return $urandom_range(3);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(255) - 128;
         3: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic svec_pkg::req_type rand_request();
      svec_pkg::req_type r;
      r.here_x = rand_coord();
      r.here_y = rand_coord();
      r.here_z = rand_coord();
      r.target_x = rand_coord();
      r.target_y = rand_coord();
      r.target_z = rand_coord();
      if ($urandom_range(7) == 0) begin
         r.target_x = r.here_x;
         r.target_y = r.here_y;
         if ($urandom_range(1) == 0) r.target_z = r.here_z;
      end
      case ($urandom_range(4))
         0: r.speed = '0;
         1: r.speed = '1;
         2: r.speed = 31'($urandom_range(32'h0002_0000));
         default: r.speed = 31'($urandom);
      endcase
      return r;
   endfunction

   task automatic send(svec_pkg::req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_pair(logic [31:0] h, logic [31:0] t, logic [30:0] s);
      svec_pkg::req_type r;
      r = '{h, h, h, t, t, t, s};
      send(r);
   endtask

   // stimulus
   initial begin
      svec_pkg::req_type r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_pair(32'h0, 32'h0, 31'h0001_0000);
      send_pair(32'h1234_5678, 32'h1234_5678, '1);
      send_pair(32'h8000_0000, 32'h7fff_ffff, '1);
      send_pair(32'h7fff_ffff, 32'h8000_0000, '1);
      send_pair(32'h8000_0000, 32'h7fff_ffff, '0);
      send_pair(32'h0, 32'h1, 31'h1);
      send_pair(32'h1, 32'h0, '1);
      send_pair(32'hffff_ffff, 32'h0, 31'h0001_0000);
      r = '{32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0, '1};
      send(r);
      r = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 31'h0002_0000};
      send(r);
      r = '{32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'hfffc_0000, 32'h0, 31'h0005_0000};
      send(r);
      r = '{32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
            32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, 31'h2aaa_aaaa};
      send(r);
      r = '{32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0,
            32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 31'h5555_5555};
      send(r);
      for (int i = 0; i < RANDOM_COUNT; i++) send(rand_request());
      req_valid <= 1'b0;
      sending_done <= 1'b1;
   end

   // result side stalls, with one long hold-off while requests keep coming
   initial begin
      repeat (2) @(posedge clock);
      forever begin
         if (!hold_off && !sending_done && (hold_now || $urandom_range(299) == 0)) begin
            hold_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (gap_length()) @(posedge clock);
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1) ? $urandom_range(30) : 0) @(posedge clock);
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (400) @(posedge clock);
      hold_now = 1'b1;
   end

   // watchdog and verdict
   initial begin
      while (!(sending_done && pending_count == 0) && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
      end else begin
         repeat (200) @(posedge clock);
         if (fail_count == 0) $display("TB_OK");
         else $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

endmodule

`default_nettype wire
